>>> rtl/cfp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cfp_pkg
// Shared constants and types of the command frame parser.
// ---------------------------------------------------------------------------
package cfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;
	localparam logic [7:0] MIN_LENGTH  = 8'd4;

	localparam logic [7:0] CMD_ID      = 8'h00;
	localparam logic [7:0] CMD_ENABLE  = 8'h01;
	localparam logic [7:0] CMD_DISABLE = 8'h02;
	localparam logic [7:0] CMD_RATE    = 8'hA8;
	localparam logic [7:0] CMD_NINE    = 8'hE2;
	localparam logic [7:0] CMD_CAL     = 8'hE3;
	localparam logic [7:0] CMD_SIX     = 8'hE4;

	localparam logic [7:0] RATE_MAX    = 8'd200;
	localparam int         PERIOD_W    = 10;
	localparam logic [PERIOD_W-1:0] RATE_BASE = 10'd1000;

	// one quotient bit per divider step
	localparam int         DIV_CNT_W   = 4;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PERIOD_W - 1);

	typedef struct packed {
		logic                status;
		logic [7:0]          command;
		logic [7:0]          value;
		logic                rate_set;
		logic [PERIOD_W-1:0] period_ms;
		logic                output_enable;
		logic                mag_meas_enable;
		logic                gravity_meas_enable;
		logic                save_request;
		logic                start_calibration;
		logic                id_request;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic step;       // byte transfer this cycle
		logic div_start;  // launch period division
		logic load_out;   // move pending result to output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic finish;     // current byte is the checksum byte
		logic rate_go;    // checksum good and rate command in range
		logic div_done;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/cfp_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cfp_in_if
// Received byte channel: valid/ready with byte and start-of-buffer flag.
// ---------------------------------------------------------------------------
interface cfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_buffer;

	modport source (output valid, output data_byte, output start_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input start_of_buffer, output ready);
endinterface
`default_nettype wire

>>> rtl/cfp_res_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cfp_res_if
// Frame result channel: valid/ready with the decoded frame fields.
// ---------------------------------------------------------------------------
interface cfp_res_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] command;
	logic [7:0] value;
	logic       rate_set;
	logic [9:0] period_ms;
	logic       output_enable;
	logic       mag_meas_enable;
	logic       gravity_meas_enable;
	logic       save_request;
	logic       start_calibration;
	logic       id_request;

	modport source (
		output valid, output status, output command, output value, output rate_set,
		output period_ms, output output_enable, output mag_meas_enable,
		output gravity_meas_enable, output save_request, output start_calibration,
		output id_request, input ready
	);
	modport sink (
		input valid, input status, input command, input value, input rate_set,
		input period_ms, input output_enable, input mag_meas_enable,
		input gravity_meas_enable, input save_request, input start_calibration,
		input id_request, output ready
	);
endinterface
`default_nettype wire

>>> rtl/command_frame_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// command_frame_parser
// Parses A5 5A framed command buffers from a byte stream and reports each
// checksummed frame with its decoded command effects.
// ---------------------------------------------------------------------------
//  port  | dir | handshake    | payload
//  rx    | in  | valid/ready  | data_byte, start_of_buffer
//  res   | out | valid/ready  | status, command, value, rate_set, period_ms,
//        |     |              | enable flags, request pulses
//
//  Ordinary bytes are accepted back to back. A checksum byte moves the result
//  to the pending register and on to the output register, for a good rate
//  command after the serial divider, which produces one quotient bit per cycle.
//  rx.ready drops from the checksum transfer until the result is loaded; it
//  also stays low while a previous result still blocks the output register.
//  Reset clears position, flags and the output valid.
// ---------------------------------------------------------------------------
module command_frame_parser import cfp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	cfp_in_if.sink    rx,
	cfp_res_if.source res
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	res_t     res_q;

	cfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cfp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (rx.data_byte),
		.start_of_buffer (rx.start_of_buffer),
		.cmd             (cmd),
		.stat            (stat),
		.res_out         (res_q)
	);

	assign res.status              = res_q.status;
	assign res.command             = res_q.command;
	assign res.value               = res_q.value;
	assign res.rate_set            = res_q.rate_set;
	assign res.period_ms           = res_q.period_ms;
	assign res.output_enable       = res_q.output_enable;
	assign res.mag_meas_enable     = res_q.mag_meas_enable;
	assign res.gravity_meas_enable = res_q.gravity_meas_enable;
	assign res.save_request        = res_q.save_request;
	assign res.start_calibration   = res_q.start_calibration;
	assign res.id_request          = res_q.id_request;

endmodule
`default_nettype wire

>>> rtl/cfp_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cfp_div
// Restoring serial divider: RATE_BASE / divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cfp_div import cfp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [7:0]          divisor,
	output logic                     done,
	output logic [PERIOD_W-1:0]      quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [7:0]           dvs_q;
	logic [7:0]           rem_q;
	logic [PERIOD_W-1:0]  quo_q;

	logic [8:0] trial;
	logic       fits;
	logic [8:0] diff;

	// remainder stays below the divisor, so 8 bits plus the incoming bit suffice
	assign trial = {rem_q, quo_q[PERIOD_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out of the quotient register as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= RATE_BASE;
		end else if (busy_q) begin
			rem_q <= fits ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[PERIOD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

>>> rtl/cfp_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cfp_dp
// Frame datapath: position tracking, checksum, held fields, mode flags,
// pending result and output register.
// ---------------------------------------------------------------------------
module cfp_dp import cfp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic     start_of_buffer,
	input  wire dp_cmd_t  cmd,
	output dp_stat_t      stat,
	output res_t          res_out
);

	logic [7:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] sum_q;
	logic [7:0] cmd_q;
	logic [7:0] val_q;
	logic       active_q;
	logic       out_on_q;
	logic       mag_q;
	logic       grav_q;
	res_t       pend_q;
	res_t       out_q;

	logic                finish;
	logic                match;
	logic                rate_ok;
	logic                nxt_out_on;
	logic                nxt_mag;
	logic                nxt_grav;
	logic                save;
	logic                cal;
	logic                ident;
	logic                div_done;
	logic [PERIOD_W-1:0] div_quot;
	res_t                load_val;

	// checksum byte: past the header and the length byte, position reached L
	assign finish  = !start_of_buffer && active_q && (pos_q != 8'd1) && (pos_q != 8'd2)
		&& !(pos_q < len_q);
	assign match   = (data_byte == sum_q);
	assign rate_ok = (cmd_q == CMD_RATE) && (val_q != 8'd0) && (val_q <= RATE_MAX);

	always_comb begin
		nxt_out_on = out_on_q;
		nxt_mag    = mag_q;
		nxt_grav   = grav_q;
		save       = 1'b0;
		cal        = 1'b0;
		ident      = 1'b0;
		if (match) begin
			case (cmd_q)
				CMD_RATE: begin
					save = rate_ok;
				end
				CMD_ID: begin
					ident = 1'b1;
				end
				CMD_ENABLE: begin
					nxt_out_on = 1'b1;
				end
				CMD_DISABLE: begin
					nxt_out_on = 1'b0;
				end
				CMD_NINE: begin
					nxt_mag  = 1'b1;
					nxt_grav = 1'b1;
					save     = 1'b1;
				end
				CMD_CAL: begin
					cal = 1'b1;
				end
				CMD_SIX: begin
					nxt_mag  = 1'b0;
					nxt_grav = 1'b1;
					save     = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		load_val           = pend_q;
		load_val.period_ms = pend_q.rate_set ? div_quot : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			cmd_q    <= '0;
			val_q    <= '0;
			active_q <= 1'b0;
			out_on_q <= 1'b0;
			mag_q    <= 1'b0;
			grav_q   <= 1'b0;
		end else if (cmd.step) begin
			if (start_of_buffer) begin
				active_q <= (data_byte == SYNC_FIRST);
				pos_q    <= 8'd1;
			end else if (active_q) begin
				if (pos_q == 8'd1) begin
					if (data_byte != SYNC_SECOND) active_q <= 1'b0;
					else pos_q <= 8'd2;
				end else if (pos_q == 8'd2) begin
					if (data_byte < MIN_LENGTH) begin
						active_q <= 1'b0;
					end else begin
						len_q <= data_byte;
						sum_q <= data_byte;
						pos_q <= 8'd3;
					end
				end else if (pos_q < len_q) begin
					sum_q <= sum_q + data_byte;
					if (pos_q == 8'd3) cmd_q <= data_byte;
					// with length four the command byte doubles as the value byte
					if (pos_q == len_q - 8'd1) val_q <= data_byte;
					pos_q <= pos_q + 8'd1;
				end else begin
					active_q <= 1'b0;
					out_on_q <= nxt_out_on;
					mag_q    <= nxt_mag;
					grav_q   <= nxt_grav;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && finish) begin
			pend_q.status              <= !match;
			pend_q.command             <= cmd_q;
			pend_q.value               <= val_q;
			pend_q.rate_set            <= match && rate_ok;
			pend_q.period_ms           <= '0;
			pend_q.output_enable       <= nxt_out_on;
			pend_q.mag_meas_enable     <= nxt_mag;
			pend_q.gravity_meas_enable <= nxt_grav;
			pend_q.save_request        <= save;
			pend_q.start_calibration   <= cal;
			pend_q.id_request          <= ident;
		end
		if (cmd.load_out) begin
			out_q <= load_val;
		end
	end

	cfp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.divisor (val_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign stat.finish   = finish;
	assign stat.rate_go  = finish && match && rate_ok;
	assign stat.div_done = div_done;
	assign res_out       = out_q;

endmodule
`default_nettype wire

>>> rtl/cfp_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cfp_ctrl
// Sequencer: byte intake, wait on the period divider, result hand-off.
// ---------------------------------------------------------------------------
module cfp_ctrl import cfp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready      = (state_q == ST_IDLE);
	assign cmd.step      = in_valid && (state_q == ST_IDLE);
	assign cmd.div_start = cmd.step && stat.rate_go;
	// output register is free when empty or being drained this cycle
	assign cmd.load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (cmd.step && stat.finish) begin
						state_q <= stat.rate_go ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (stat.div_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.load_out) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
